@@ src/triangle_tangent_binormal_macros.svh @@
// Assertion macros for the tangent and binormal generator checker.
`ifndef TRIANGLE_TANGENT_BINORMAL_MACROS_SVH
`define TRIANGLE_TANGENT_BINORMAL_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define TTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ttb check failed");

// Next-cycle implication, also checked while reset is held.
`define TTB_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ttb check failed");

`endif

@@ src/ttb_pkg.sv @@
// Shared constants and types of the tangent and binormal generator.
`timescale 1ns / 1ps
package ttb_pkg;
    localparam int POS_WIDTH     = 32;  // input field width
    localparam int VEC_WIDTH     = 16;  // output component width, Q2.14
    localparam int NORM_BITS     = 30;  // magnitudes are cut to this many bits
    localparam int Q14_SHIFT     = 14;
    localparam int QUO_BITS      = 15;  // quotient never exceeds 16384
    localparam int LEN_WIDTH     = 31;  // vector length width
    localparam int SUM_WIDTH     = 62;  // sum of three squares
    localparam int ROOT_WIDTH    = 63;  // square root working width
    localparam int NUM_WIDTH     = 45;  // rounded dividend width
    localparam int SQRT_STEPS    = 32;
    localparam int MUL_STEPS     = 14;
    localparam int VERTS_PER_TRI = 3;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] tangent_x;
        logic signed [VEC_WIDTH-1:0] tangent_y;
        logic signed [VEC_WIDTH-1:0] tangent_z;
        logic signed [VEC_WIDTH-1:0] binormal_x;
        logic signed [VEC_WIDTH-1:0] binormal_y;
        logic signed [VEC_WIDTH-1:0] binormal_z;
        logic                        degenerate;
    } t_res;
endpackage

@@ src/ttb_if.sv @@
// Vertex and result channel interfaces of the tangent and binormal generator.
`timescale 1ns / 1ps
interface ttb_vtx_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ttb_pkg::POS_WIDTH-1:0]  pos_x;
    logic signed [ttb_pkg::POS_WIDTH-1:0]  pos_y;
    logic signed [ttb_pkg::POS_WIDTH-1:0]  pos_z;
    logic signed [ttb_pkg::POS_WIDTH-1:0]  tex_u;
    logic signed [ttb_pkg::POS_WIDTH-1:0]  tex_v;
    logic                                  mesh_end;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_end, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, mesh_end, output ready);
endinterface

interface ttb_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ttb_pkg::VEC_WIDTH-1:0]  tangent_x;
    logic signed [ttb_pkg::VEC_WIDTH-1:0]  tangent_y;
    logic signed [ttb_pkg::VEC_WIDTH-1:0]  tangent_z;
    logic signed [ttb_pkg::VEC_WIDTH-1:0]  binormal_x;
    logic signed [ttb_pkg::VEC_WIDTH-1:0]  binormal_y;
    logic signed [ttb_pkg::VEC_WIDTH-1:0]  binormal_z;
    logic                                  degenerate;
    logic                                  triangle_last;
    logic                                  mesh_last;

    modport source (output valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                    binormal_z, degenerate, triangle_last, mesh_last, input ready);
    modport sink (input valid, tangent_x, tangent_y, tangent_z, binormal_x, binormal_y,
                  binormal_z, degenerate, triangle_last, mesh_last, output ready);
endinterface

@@ src/ttb_front.sv @@
// Front end: collects vertices into triangles and forms edge and UV deltas.
`timescale 1ns / 1ps
module ttb_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ttb_vtx_if.sink                         i_vtx,
    output logic                            o_tri_valid,
    input  logic                            i_tri_ready,
    output logic [10*(COORD_WIDTH+1):0]     o_tri_data
);
    localparam int DW = COORD_WIDTH + 1;

    localparam logic [1:0] PH_V0 = 2'd0;
    localparam logic [1:0] PH_V1 = 2'd1;
    localparam logic [1:0] PH_V2 = 2'd2;

    logic [1:0]             r_phase;
    logic [1:0]             phase;
    logic [1:0]             n_phase;
    logic [COORD_WIDTH-1:0] r_hpos [6];
    logic [COORD_WIDTH-1:0] r_htex [4];
    logic [COORD_WIDTH-1:0] in_pos [3];
    logic signed [DW-1:0]   e1 [3];
    logic signed [DW-1:0]   e2 [3];
    logic signed [DW-1:0]   du1, dv1, du2, dv2;
    logic                   accept;

    function automatic logic signed [DW-1:0] sx(input logic [COORD_WIDTH-1:0] v);
        return signed'({v[COORD_WIDTH-1], v});
    endfunction

    // The unused fourth phase code behaves like the first vertex.
    assign phase = (r_phase == PH_V1 || r_phase == PH_V2) ? r_phase : PH_V0;

    assign in_pos[0] = i_vtx.pos_x[COORD_WIDTH-1:0];
    assign in_pos[1] = i_vtx.pos_y[COORD_WIDTH-1:0];
    assign in_pos[2] = i_vtx.pos_z[COORD_WIDTH-1:0];

    assign i_vtx.ready = (phase != PH_V2) || i_tri_ready;
    assign accept      = i_vtx.valid && i_vtx.ready;
    assign o_tri_valid = i_vtx.valid && (phase == PH_V2);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = sx(r_hpos[3+k]) - sx(r_hpos[k]);
            e2[k] = sx(in_pos[k]) - sx(r_hpos[k]);
        end
        du1 = sx(r_htex[2]) - sx(r_htex[0]);
        dv1 = sx(r_htex[3]) - sx(r_htex[1]);
        du2 = sx(i_vtx.tex_u[COORD_WIDTH-1:0]) - sx(r_htex[0]);
        dv2 = sx(i_vtx.tex_v[COORD_WIDTH-1:0]) - sx(r_htex[1]);
    end

    assign o_tri_data = {i_vtx.mesh_end, dv2, du2, dv1, du1,
                         e2[2], e2[1], e2[0], e1[2], e1[1], e1[0]};

    always_comb begin
        case (phase)
            PH_V0:   n_phase = i_vtx.mesh_end ? PH_V0 : PH_V1;
            PH_V1:   n_phase = i_vtx.mesh_end ? PH_V0 : PH_V2;
            default: n_phase = PH_V0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_V0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    // Vertex store; a mesh end on a partial triangle simply drops it.
    always_ff @(posedge i_clk) begin
        if (accept && phase != PH_V2) begin
            for (int k = 0; k < 3; k++) begin
                if (phase == PH_V1) begin
                    r_hpos[3+k] <= in_pos[k];
                end else begin
                    r_hpos[k] <= in_pos[k];
                end
            end
            if (phase == PH_V1) begin
                r_htex[2] <= i_vtx.tex_u[COORD_WIDTH-1:0];
                r_htex[3] <= i_vtx.tex_v[COORD_WIDTH-1:0];
            end else begin
                r_htex[0] <= i_vtx.tex_u[COORD_WIDTH-1:0];
                r_htex[1] <= i_vtx.tex_v[COORD_WIDTH-1:0];
            end
        end
    end
endmodule

@@ src/ttb_fifo.sv @@
// Small register queue between the front end and the back end.
`timescale 1ns / 1ps
module ttb_fifo #(
    parameter int WIDTH = 331,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ src/ttb_back.sv @@
// Back end: cross products, normalization, square root, division and result beats.
`timescale 1ns / 1ps
module ttb_back #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tri_valid,
    output logic                        o_tri_ready,
    input  logic [10*(COORD_WIDTH+1):0] i_tri_data,
    ttb_res_if.source                   o_res
);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int MW  = (DW > ttb_pkg::LEN_WIDTH) ? DW : ttb_pkg::LEN_WIDTH;
    localparam int PW  = 2 * MW;
    localparam int AW  = 2 * DW + 1;
    localparam int VW  = ttb_pkg::VEC_WIDTH;
    localparam int LW  = ttb_pkg::LEN_WIDTH;
    localparam int RW  = ttb_pkg::ROOT_WIDTH;
    localparam int SW  = ttb_pkg::SUM_WIDTH;
    localparam int QB  = ttb_pkg::QUO_BITS;
    localparam int NB  = ttb_pkg::NORM_BITS;
    localparam int NW  = ttb_pkg::NUM_WIDTH;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [2:0] ACC_DET = 3'd6;
    localparam logic [1:0] LAST_BEAT = 2'(ttb_pkg::VERTS_PER_TRI - 1);

    logic [3:0]              r_state;
    logic [10*DW:0]          r_rec;
    logic [4:0]              r_cnt;
    logic                    r_vec;
    logic [1:0]              r_comp;
    logic signed [AW-1:0]    r_acc [7];
    logic signed [PW-1:0]    r_prod;
    logic                    r_pvld;
    logic [2:0]              r_pdst;
    logic                    r_psub;
    logic [AW-1:0]           r_mag [3];
    logic                    r_neg [3];
    logic [SW-1:0]           r_sum;
    logic [SW-1:0]           r_v;
    logic [RW-1:0]           r_root;
    logic [RW-1:0]           r_bit;
    logic [QB-1:0]           r_num_lo;
    logic [LW-1:0]           r_rem;
    logic [QB-1:0]           r_quo;
    logic signed [VW-1:0]    r_q [6];
    logic                    r_degen;
    logic                    r_ovalid;
    logic [1:0]              r_obeat;
    logic                    r_oend;
    ttb_pkg::t_res           r_ores;

    logic signed [DW-1:0]    e1 [3];
    logic signed [DW-1:0]    e2 [3];
    logic signed [DW-1:0]    du1, dv1, du2, dv2;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic [2:0]              mul_dst;
    logic                    mul_sub;
    logic                    mul_go;
    logic signed [AW-1:0]    ld_val [3];
    logic [AW-1:0]           ld_mag [3];
    logic                    ld_zero;
    logic                    det_zero;
    logic                    det_neg;
    logic                    hi_any;
    logic [RW-1:0]           sq_trial;
    logic                    sq_ge;
    logic [NW-1:0]           num;
    logic [LW:0]             dv_trial;
    logic [LW:0]             len_ext;
    logic                    dv_ge;
    logic [LW:0]             dv_rem;
    logic [QB-1:0]           quo_next;
    logic [VW-1:0]           q_mag;
    logic signed [VW-1:0]    q_val;
    logic [2:0]              q_idx;
    logic                    out_free;
    logic                    xfer;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1[k] = signed'(r_rec[k*DW +: DW]);
            e2[k] = signed'(r_rec[(k+3)*DW +: DW]);
        end
        du1 = signed'(r_rec[6*DW +: DW]);
        dv1 = signed'(r_rec[7*DW +: DW]);
        du2 = signed'(r_rec[8*DW +: DW]);
        dv2 = signed'(r_rec[9*DW +: DW]);
    end

    // Operand selection for the one shared multiplier. Each vector component
    // takes two products, the second subtracted; the determinant comes last.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_dst = '0;
        mul_sub = 1'b0;
        mul_go  = 1'b0;
        if (r_state == S_MUL && r_cnt < 5'(ttb_pkg::MUL_STEPS)) begin
            mul_go = 1'b1;
            if (r_cnt[3:2] == 2'd3) begin
                mul_dst = ACC_DET;
                mul_sub = r_cnt[0];
                mul_a   = MW'(r_cnt[0] ? du2 : du1);
                mul_b   = MW'(r_cnt[0] ? dv1 : dv2);
            end else begin
                mul_dst = r_cnt[1] ? 3'(r_cnt[3:2]) + 3'd3 : 3'(r_cnt[3:2]);
                mul_sub = r_cnt[0];
                case (r_cnt[1:0])
                    2'd0: begin
                        mul_a = MW'(dv2);
                        mul_b = MW'(e1[r_cnt[3:2]]);
                    end
                    2'd1: begin
                        mul_a = MW'(dv1);
                        mul_b = MW'(e2[r_cnt[3:2]]);
                    end
                    2'd2: begin
                        mul_a = MW'(du2);
                        mul_b = MW'(e1[r_cnt[3:2]]);
                    end
                    default: begin
                        mul_a = MW'(du1);
                        mul_b = MW'(e2[r_cnt[3:2]]);
                    end
                endcase
            end
        end else if (r_state == S_SQ && r_cnt < 5'd3) begin
            mul_go = 1'b1;
            mul_a  = signed'(MW'({1'b0, r_mag[r_cnt[1:0]][NB-1:0]}));
            mul_b  = mul_a;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ld_val[k] = r_vec ? r_acc[3+k] : r_acc[k];
            ld_mag[k] = ld_val[k][AW-1] ? AW'(-ld_val[k]) : AW'(ld_val[k]);
        end
        ld_zero  = (ld_val[0] == '0) && (ld_val[1] == '0) && (ld_val[2] == '0);
        det_zero = (r_acc[6] == '0);
        det_neg  = r_acc[6][AW-1];
        hi_any   = ((r_mag[0] | r_mag[1] | r_mag[2]) >> NB) != '0;
    end

    assign sq_trial = r_root + r_bit;
    assign sq_ge    = RW'(r_v) >= sq_trial;

    assign num      = NW'({r_mag[r_comp][NB-1:0], ttb_pkg::Q14_SHIFT'(0)})
                      + NW'(r_root[LW-1:1]);
    assign len_ext  = {1'b0, r_root[LW-1:0]};
    assign dv_trial = {r_rem, r_num_lo[QB-1]};
    assign dv_ge    = dv_trial >= len_ext;
    assign dv_rem   = dv_ge ? dv_trial - len_ext : dv_trial;
    assign quo_next = {r_quo[QB-2:0], dv_ge};
    assign q_mag    = VW'(quo_next);
    assign q_val    = r_neg[r_comp] ? signed'(VW'(0) - q_mag) : signed'(q_mag);
    assign q_idx    = r_vec ? 3'(r_comp) + 3'd3 : 3'(r_comp);

    assign out_free    = !r_ovalid || (o_res.ready && r_obeat == LAST_BEAT);
    assign xfer        = (r_state == S_DONE) && out_free;
    assign o_tri_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pvld  <= 1'b0;
        end else begin
            r_pvld <= mul_go;
            case (r_state)
                S_IDLE: begin
                    if (i_tri_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == 5'(ttb_pkg::MUL_STEPS)) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (det_zero || ld_zero) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!hi_any) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == 5'd4) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        if (r_comp != 2'd2) begin
                            r_state <= S_DIVI;
                        end else if (!r_vec) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_pdst  <= mul_dst;
        r_psub  <= mul_sub;
        if (r_pvld) begin
            if (r_state == S_MUL) begin
                r_acc[r_pdst] <= r_psub ? r_acc[r_pdst] - AW'(r_prod) : AW'(r_prod);
            end else begin
                r_sum <= r_sum + SW'(r_prod);
            end
        end
        case (r_state)
            S_IDLE: begin
                r_rec   <= i_tri_data;
                r_cnt   <= '0;
                r_vec   <= 1'b0;
                r_degen <= 1'b0;
            end
            S_MUL: begin
                r_cnt <= r_cnt + 1'b1;
            end
            S_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= ld_mag[k];
                    r_neg[k] <= ld_val[k][AW-1] ^ det_neg;
                end
                r_degen <= det_zero || ld_zero;
            end
            S_SHIFT: begin
                if (hi_any) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end
                end
                r_cnt <= '0;
                r_sum <= '0;
            end
            S_SQ: begin
                // The third square passes through the product register before it reaches
                // the sum, so the root operand is latched from the sum as this state ends.
                r_cnt  <= (r_cnt == 5'd4) ? 5'(ttb_pkg::SQRT_STEPS - 1) : r_cnt + 1'b1;
                r_v    <= r_sum;
                r_root <= '0;
                r_bit  <= RW'(1) << (RW - 1);
            end
            S_SQRT: begin
                // One result bit per cycle, the classic digit-by-digit root.
                if (sq_ge) begin
                    r_v    <= SW'(RW'(r_v) - sq_trial);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt - 1'b1;
                r_comp <= '0;
            end
            S_DIVI: begin
                r_rem    <= LW'(num[NW-1:QB]);
                r_num_lo <= num[QB-1:0];
                r_quo    <= '0;
                r_cnt    <= 5'(QB - 1);
            end
            S_DIV: begin
                r_rem    <= dv_rem[LW-1:0];
                r_num_lo <= {r_num_lo[QB-2:0], 1'b0};
                r_quo    <= quo_next;
                r_cnt    <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_q[q_idx] <= q_val;
                    r_comp     <= r_comp + 1'b1;
                    if (r_comp == 2'd2) begin
                        r_vec <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output stage: holds one finished pair and sends it as three beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_obeat  <= '0;
        end else if (xfer) begin
            r_ovalid <= 1'b1;
            r_obeat  <= '0;
        end else if (r_ovalid && o_res.ready) begin
            if (r_obeat == LAST_BEAT) begin
                r_ovalid <= 1'b0;
            end
            r_obeat <= r_obeat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_oend                <= r_rec[10*DW];
            r_ores.degenerate     <= r_degen;
            r_ores.tangent_x      <= r_degen ? '0 : r_q[0];
            r_ores.tangent_y      <= r_degen ? '0 : r_q[1];
            r_ores.tangent_z      <= r_degen ? '0 : r_q[2];
            r_ores.binormal_x     <= r_degen ? '0 : r_q[3];
            r_ores.binormal_y     <= r_degen ? '0 : r_q[4];
            r_ores.binormal_z     <= r_degen ? '0 : r_q[5];
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.tangent_x     = r_ores.tangent_x;
    assign o_res.tangent_y     = r_ores.tangent_y;
    assign o_res.tangent_z     = r_ores.tangent_z;
    assign o_res.binormal_x    = r_ores.binormal_x;
    assign o_res.binormal_y    = r_ores.binormal_y;
    assign o_res.binormal_z    = r_ores.binormal_z;
    assign o_res.degenerate    = r_ores.degenerate;
    assign o_res.triangle_last = (r_obeat == LAST_BEAT);
    assign o_res.mesh_last     = (r_obeat == LAST_BEAT) && r_oend;
endmodule

@@ src/triangle_tangent_binormal.sv @@
// Top level of the triangle tangent and binormal generator.
`timescale 1ns / 1ps
// Usage: vertices enter on i_vtx, one beat per vertex, with Q16.16 position,
// Q16.16 texture coordinate and a mesh_end flag. Every third vertex closes a
// triangle; mesh_end on the first or second vertex drops the partial triangle.
// Each triangle leaves on o_res as three identical beats carrying the unit
// tangent and binormal in Q2.14; triangle_last marks the third beat and
// mesh_last marks it too when mesh_end came with the triangle's third vertex.
// Timing: the first two vertices of a triangle are taken one per cycle. The
// third passes into a two-entry queue and the back end works through it in
// turn (a degenerate triangle ends as soon as a zero determinant or zero
// vector is found): fourteen products through one shared multiplier, then
// per vector magnitude shifting, three squares, a bit-serial square root and
// three bit-serial divisions. That back-end loop sets the sustained rate of
// one triangle per pass. A finished pair sits in an output register, so the
// back end starts the next triangle while the receiver stalls; beats simply
// wait there until ready is seen. Reset, synchronous and active low, returns
// the vertex count to the first vertex and empties queue and output.
module triangle_tangent_binormal #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttb_vtx_if.sink   i_vtx,
    ttb_res_if.source o_res
);
    localparam int TRI_W = 10 * (COORD_WIDTH + 1) + 1;

    logic             fr_valid;
    logic             fr_ready;
    logic [TRI_W-1:0] fr_data;
    logic             bk_valid;
    logic             bk_ready;
    logic [TRI_W-1:0] bk_data;

    // Vertex gathering and delta forming.
    ttb_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vtx      (i_vtx),
        .o_tri_valid(fr_valid),
        .i_tri_ready(fr_ready),
        .o_tri_data (fr_data)
    );

    // Triangle queue decoupling the front end from the arithmetic.
    ttb_fifo #(
        .WIDTH(TRI_W),
        .DEPTH(ttb_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(fr_valid),
        .o_ready(fr_ready),
        .i_data (fr_data),
        .o_valid(bk_valid),
        .i_ready(bk_ready),
        .o_data (bk_data)
    );

    // Cross products, normalization and the three result beats.
    ttb_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tri_valid(bk_valid),
        .o_tri_ready(bk_ready),
        .i_tri_data (bk_data),
        .o_res      (o_res)
    );
endmodule

@@ src/ttb_checker.sv @@
// Port-level checks on the result channel of the tangent and binormal generator.
`timescale 1ns / 1ps
`include "triangle_tangent_binormal_macros.svh"
module ttb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [ttb_pkg::VEC_WIDTH-1:0] i_tx,
    input logic signed [ttb_pkg::VEC_WIDTH-1:0] i_ty,
    input logic signed [ttb_pkg::VEC_WIDTH-1:0] i_tz,
    input logic signed [ttb_pkg::VEC_WIDTH-1:0] i_bx,
    input logic signed [ttb_pkg::VEC_WIDTH-1:0] i_by,
    input logic signed [ttb_pkg::VEC_WIDTH-1:0] i_bz,
    input logic                               i_degen,
    input logic                               i_tri_last,
    input logic                               i_mesh_last
);
    // Reset empties the output stage.
    `TTB_ASSERT_NXT(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)

    // A stalled beat stays put.
    `TTB_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n && i_out_valid && !i_out_ready, i_out_valid && $stable(i_tx) && $stable(i_by) && $stable(i_tri_last))

    // The three beats of a triangle follow without a gap in valid.
    `TTB_ASSERT_NXT(a_beats_follow, i_clk, i_rst_n && i_out_valid && i_out_ready && !i_tri_last, i_out_valid)

    // A degenerate triangle carries zero vectors.
    `TTB_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, i_out_valid && i_degen, i_tx == '0 && i_ty == '0 && i_tz == '0 && i_bx == '0 && i_by == '0 && i_bz == '0)

    // The mesh can only end on a triangle's last beat.
    `TTB_ASSERT_IMP(a_mesh_on_tri, i_clk, i_rst_n, i_out_valid && i_mesh_last, i_tri_last)
endmodule

bind triangle_tangent_binormal ttb_checker u_ttb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_tx       (o_res.tangent_x),
    .i_ty       (o_res.tangent_y),
    .i_tz       (o_res.tangent_z),
    .i_bx       (o_res.binormal_x),
    .i_by       (o_res.binormal_y),
    .i_bz       (o_res.binormal_z),
    .i_degen    (o_res.degenerate),
    .i_tri_last (o_res.triangle_last),
    .i_mesh_last(o_res.mesh_last)
);
